// ===== rtl/vsa_pkg.sv =====
// Shared types and constants of the voice slot allocator.
`default_nettype none
package vsa_pkg;

	localparam int OP_W   = 3;
	localparam int ID_W   = 5;
	localparam int GEN_W  = 32;
	localparam int PRIO_W = 8;
	localparam int SEQ_W  = 64;
	localparam int CNT_W  = 5;
	localparam int IN_W   = 56;
	localparam int OUT_W  = 80;

	typedef enum logic [OP_W-1:0] {
		OP_PLAY     = 3'd0,
		OP_STOP     = 3'd1,
		OP_STOP_ALL = 3'd2,
		OP_STARTED  = 3'd3,
		OP_ENDED    = 3'd4,
		OP_QUERY    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STS_DONE      = 3'd0,
		STS_STOLE     = 3'd1,
		STS_NO_VOICE  = 3'd2,
		STS_UNKNOWN   = 3'd3,
		STS_BAD_STATE = 3'd4,
		STS_IGNORED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE   = 2'd0,
		SLOT_PSTART = 2'd1,
		SLOT_ACTIVE = 2'd2,
		SLOT_PSTOP  = 2'd3
	} slot_state_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_SCAN,
		FSM_PLAY,
		FSM_EXEC,
		FSM_FIN
	} fsm_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic              looping;
		logic [SEQ_W-1:0]  seq;
	} rank_key_t;

	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic             stealable;
		rank_key_t        key;
	} slot_rec_t;

	localparam slot_rec_t REC_RESET = '{
		gen:       32'd1,
		stealable: 1'b0,
		key:       '{prio: 8'd0, looping: 1'b0, seq: 64'd0}
	};

	function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + 32'd1;
		return (n == '0) ? 32'd1 : n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vsa_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/vsa_rank.sv =====
// Steal ranking compare unit: lower priority, then non-looping, then oldest.
`default_nettype none
module vsa_rank (
	input  wire logic              cand_ok,
	input  wire vsa_pkg::rank_key_t cand_key,
	input  wire logic              best_found,
	input  wire vsa_pkg::rank_key_t best_key,
	output logic                   take
);
	import vsa_pkg::*;

	logic better;

	always_comb begin
		if (cand_key.prio != best_key.prio) begin
			better = cand_key.prio < best_key.prio;
		end else if (cand_key.looping != best_key.looping) begin
			better = !cand_key.looping;
		end else begin
			better = cand_key.seq < best_key.seq;
		end
		take = cand_ok && (!best_found || better);
	end

endmodule
`default_nettype wire

// ===== rtl/voice_slot_allocator_with_steal.sv =====
// Voice slot allocator: top level with sequencer, slot table and output register.
// Play: decode, then the slot record RAM is scanned one slot per cycle through the shared
// ranking unit, then the play and fin states load the result.
// Stop, events, query: decode, exec and fin states; stop-all, rejected play, undefined op: decode and fin.
// One transaction at a time: next input taken in the cycle after the result register loads.
// Reset (arst_n low): all slots free, generations 1, attributes 0, sequence 1, disabled.
`default_nettype none
module voice_slot_allocator_with_steal #(
	parameter int VOICES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_wr_data,  // enabled
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// op[2:0], slot_id[7:3], handle_generation[39:8], priority_req[47:40],
	// stealable[48], looping[49], allow_steal[50], clip_valid[51], zero[55:52]
	input  wire logic [vsa_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// status[2:0], result_slot_id[7:3], result_generation[39:8],
	// previous_generation[71:40], playing[72], active_count[77:73], zero[79:78]
	output logic      [vsa_pkg::OUT_W-1:0]  m_tdata
);
	import vsa_pkg::*;

	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);
	localparam logic [6:0] VOICES_7 = 7'(VOICES);
	localparam int REC_W = $bits(slot_rec_t);

	function automatic logic [ID_W-1:0] slot_num(input logic [IW-1:0] idx);
		logic [6:0] n;
		n = 7'(idx) + 7'd1;
		return n[ID_W-1:0];
	endfunction

	fsm_t state_q, state_d;

	logic enabled_q;
	slot_state_t slot_state_q [VOICES];
	logic [VOICES-1:0] written_q;
	logic [CW-1:0] cnt_q;
	logic [SEQ_W-1:0] next_seq_q, next_seq_inc;
	logic [IW-1:0] ptr_q;
	logic rd_valid_q;

	op_t op_q;
	logic [IW-1:0] hidx_q;
	logic hknown_q;
	logic [GEN_W-1:0] hgen_q;
	logic [PRIO_W-1:0] prio_q;
	logic stl_q, lp_q, allow_q, clip_q;

	logic free_found_q, best_found_q;
	logic [IW-1:0] free_idx_q, best_idx_q;
	logic [GEN_W-1:0] free_gen_q, best_gen_q;
	rank_key_t best_key_q;

	status_t res_status_q;
	logic [ID_W-1:0] res_slot_q;
	logic [GEN_W-1:0] res_gen_q, res_pgen_q;
	logic res_playing_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic m_tvalid_q;

	logic accept, out_load;
	logic [ID_W-1:0] in_id;
	logic in_known;
	logic [6:0] id_m1;
	logic [IW-1:0] in_hidx;

	logic wr_en;
	logic [IW-1:0] wr_addr, rd_addr;
	slot_rec_t wr_data, rd_data, rec;
	slot_state_t scan_st, hst;
	logic cand_ok, take, hmatch, do_steal;
	logic [6:0] cnt7;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == FSM_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	assign in_id = s_tdata[7:3];
	assign in_known = (in_id != '0) && ({2'b00, in_id} <= VOICES_7);
	assign id_m1 = {2'b00, in_id} - 7'd1;
	assign in_hidx = in_known ? id_m1[IW-1:0] : '0;

	assign rec = rd_valid_q ? rd_data : REC_RESET;
	assign scan_st = slot_state_q[ptr_q];
	assign hst = slot_state_q[hidx_q];
	assign hmatch = hknown_q && (rec.gen == hgen_q);
	assign cand_ok = (scan_st == SLOT_ACTIVE) && rec.stealable && (rec.key.prio <= prio_q);
	assign do_steal = allow_q && best_found_q;
	assign next_seq_inc = (next_seq_q + 64'd1 == '0) ? 64'd1 : next_seq_q + 64'd1;
	assign cnt7 = 7'(cnt_q);

	vsa_rank u_rank (
		.cand_ok    (cand_ok),
		.cand_key   (rec.key),
		.best_found (best_found_q),
		.best_key   (best_key_q),
		.take       (take)
	);

	vsa_ram #(
		.WIDTH (REC_W),
		.DEPTH (VOICES),
		.AW    (IW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = hidx_q;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = REC_RESET;
		out_load = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_DECODE;
				end
			end
			FSM_DECODE: begin
				case (op_q)
					OP_PLAY: begin
						if (enabled_q && clip_q) begin
							rd_addr = '0;
							state_d = FSM_SCAN;
						end else begin
							state_d = FSM_FIN;
						end
					end
					OP_STOP, OP_STARTED, OP_ENDED, OP_QUERY: begin
						state_d = FSM_EXEC;
					end
					default: state_d = FSM_FIN;
				endcase
			end
			FSM_SCAN: begin
				rd_addr = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);
				if (ptr_q == LAST_IDX) begin
					state_d = FSM_PLAY;
				end
			end
			FSM_PLAY: begin
				wr_data.stealable = stl_q;
				wr_data.key = '{prio: prio_q, looping: lp_q, seq: next_seq_q};
				if (free_found_q) begin
					wr_en = 1'b1;
					wr_addr = free_idx_q;
					wr_data.gen = free_gen_q;
				end else if (do_steal) begin
					wr_en = 1'b1;
					wr_addr = best_idx_q;
					wr_data.gen = bump_gen(best_gen_q);
				end
				state_d = FSM_FIN;
			end
			FSM_EXEC: begin
				if (op_q == OP_ENDED && hmatch) begin
					wr_en = 1'b1;
					wr_addr = hidx_q;
					wr_data.gen = bump_gen(rec.gen);
				end
				state_d = FSM_FIN;
			end
			FSM_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				slot_state_q[i] <= SLOT_FREE;
			end
			written_q <= '0;
			cnt_q <= '0;
			next_seq_q <= 64'd1;
			ptr_q <= '0;
			rd_valid_q <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				enabled_q <= cfg_wr_data;
			end
			rd_valid_q <= written_q[rd_addr];
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				FSM_IDLE: begin
					free_found_q <= 1'b0;
					best_found_q <= 1'b0;
					ptr_q <= '0;
				end
				FSM_DECODE: begin
					if (op_q == OP_STOP_ALL && enabled_q) begin
						for (int i = 0; i < VOICES; i++) begin
							if (slot_state_q[i] != SLOT_FREE) begin
								slot_state_q[i] <= SLOT_PSTOP;
							end
						end
					end
				end
				FSM_SCAN: begin
					ptr_q <= ptr_q + IW'(1);
					if (scan_st == SLOT_FREE) begin
						free_found_q <= 1'b1;
					end
					if (take) begin
						best_found_q <= 1'b1;
					end
				end
				FSM_PLAY: begin
					if (free_found_q) begin
						slot_state_q[free_idx_q] <= SLOT_PSTART;
						cnt_q <= cnt_q + CW'(1);
						next_seq_q <= next_seq_inc;
					end else if (do_steal) begin
						slot_state_q[best_idx_q] <= SLOT_PSTART;
						next_seq_q <= next_seq_inc;
					end
				end
				FSM_EXEC: begin
					if (hmatch) begin
						case (op_q)
							OP_STOP: begin
								if (hst == SLOT_PSTART || hst == SLOT_ACTIVE) begin
									slot_state_q[hidx_q] <= SLOT_PSTOP;
								end
							end
							OP_STARTED: begin
								if (hst == SLOT_PSTART) begin
									slot_state_q[hidx_q] <= SLOT_ACTIVE;
								end
							end
							OP_ENDED: begin
								slot_state_q[hidx_q] <= SLOT_FREE;
								if (hst != SLOT_FREE) begin
									cnt_q <= cnt_q - CW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					op_q <= op_t'(s_tdata[2:0]);
					hidx_q <= in_hidx;
					hknown_q <= in_known;
					hgen_q <= s_tdata[39:8];
					prio_q <= s_tdata[47:40];
					stl_q <= s_tdata[48];
					lp_q <= s_tdata[49];
					allow_q <= s_tdata[50];
					clip_q <= s_tdata[51];
					res_status_q <= STS_DONE;
					res_slot_q <= '0;
					res_gen_q <= '0;
					res_pgen_q <= '0;
					res_playing_q <= 1'b0;
				end
			end
			FSM_DECODE: begin
				case (op_q)
					OP_PLAY: begin
						if (!enabled_q || !clip_q) begin
							res_status_q <= STS_UNKNOWN;
						end
					end
					OP_STOP_ALL: begin
						if (!enabled_q) begin
							res_status_q <= STS_UNKNOWN;
						end
					end
					OP_STOP, OP_STARTED, OP_ENDED, OP_QUERY: ;
					default: res_status_q <= STS_IGNORED;
				endcase
			end
			FSM_SCAN: begin
				if (scan_st == SLOT_FREE && !free_found_q) begin
					free_idx_q <= ptr_q;
					free_gen_q <= rec.gen;
				end
				if (take) begin
					best_idx_q <= ptr_q;
					best_key_q <= rec.key;
					best_gen_q <= rec.gen;
				end
			end
			FSM_PLAY: begin
				if (free_found_q) begin
					res_slot_q <= slot_num(free_idx_q);
					res_gen_q <= free_gen_q;
				end else if (do_steal) begin
					res_status_q <= STS_STOLE;
					res_slot_q <= slot_num(best_idx_q);
					res_gen_q <= bump_gen(best_gen_q);
					res_pgen_q <= best_gen_q;
				end else begin
					res_status_q <= STS_NO_VOICE;
				end
			end
			FSM_EXEC: begin
				case (op_q)
					OP_STOP: begin
						if (!hmatch) begin
							res_status_q <= STS_UNKNOWN;
						end else if (hst == SLOT_FREE || hst == SLOT_PSTOP) begin
							res_status_q <= STS_BAD_STATE;
						end
					end
					OP_STARTED: begin
						if (!hmatch || hst != SLOT_PSTART) begin
							res_status_q <= STS_IGNORED;
						end
					end
					OP_ENDED: begin
						if (!hmatch) begin
							res_status_q <= STS_IGNORED;
						end
					end
					OP_QUERY: begin
						if (!hmatch) begin
							res_status_q <= STS_UNKNOWN;
						end else begin
							res_playing_q <= (hst == SLOT_PSTART) || (hst == SLOT_ACTIVE);
						end
					end
					default: ;
				endcase
			end
			FSM_FIN: begin
				if (out_load) begin
					m_tdata_q <= {2'b00, cnt7[CNT_W-1:0], res_playing_q, res_pgen_q,
						res_gen_q, res_slot_q, res_status_q};
				end
			end
			default: ;
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VOICES))
		else $error("voice count above table size");

	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_seq_q != '0)
		else $error("start sequence reached zero");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN || state_q == FSM_DECODE) |-> !wr_en)
		else $error("slot table written during scan");

	a_steal_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status_q == STS_STOLE) |->
			(res_gen_q != '0) && (res_gen_q != res_pgen_q))
		else $error("stolen voice generation not bumped");

	a_fin_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid_q && state_q == FSM_IDLE)
		else $error("result transaction lost");

endmodule
`default_nettype wire
